// ===== hw/rtl/lbbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbr_pkg
// Shared constants, box word type, controller states and the control and
// status structs between the box walk and the controller.
// ----------------------------------------------------------------------------
package lbbr_pkg;

    localparam int MAX_BOXES = 8;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int AREA_W    = 2 * DIFF_W;
    localparam int GROWTH_W  = AREA_W + 1;
    localparam int THR_W     = 6;
    localparam int LIMIT_W   = AREA_W + THR_W + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             rd_fire;
        idx_t             rd_idx;
        box_t             rect;
        logic [THR_W-1:0] thr;
    } walk_ctl_t;

    typedef struct packed {
        logic busy;
        logic hit;
        logic found;
        idx_t found_idx;
        box_t found_box;
        idx_t best_idx;
        box_t best_box;
    } walk_res_t;

endpackage

// ===== hw/rtl/lbbr_box_mem.sv =====
// ----------------------------------------------------------------------------
// lbbr_box_mem
// Box store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lbbr_box_mem (
    input  logic           clk,
    input  logic           rd_en,
    input  lbbr_pkg::idx_t rd_addr,
    output lbbr_pkg::box_t rd_data,
    input  logic           wr_en,
    input  lbbr_pkg::idx_t wr_addr,
    input  lbbr_pkg::box_t wr_data
);

    lbbr_pkg::box_t mem [lbbr_pkg::MAX_BOXES];
    lbbr_pkg::box_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lbbr_walk.sv =====
// ----------------------------------------------------------------------------
// lbbr_walk
// Box walk pipeline: union and overlap test, area products, growth, then
// first-fit and least-growth tracking over the stored boxes.
// ----------------------------------------------------------------------------
module lbbr_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  lbbr_pkg::walk_ctl_t ctl,
    input  lbbr_pkg::box_t      rd_data,
    output lbbr_pkg::walk_res_t res
);

    function automatic logic signed [lbbr_pkg::DIFF_W-1:0] span(
        input logic signed [lbbr_pkg::COORD_W-1:0] lo,
        input logic signed [lbbr_pkg::COORD_W-1:0] hi
    );
        span = $signed({hi[lbbr_pkg::COORD_W-1], hi}) - $signed({lo[lbbr_pkg::COORD_W-1], lo});
    endfunction

    logic           v1_reg;
    lbbr_pkg::idx_t idx1_reg;

    logic           v2_reg;
    lbbr_pkg::idx_t idx2_reg;
    lbbr_pkg::box_t box2_reg;
    logic           hit2_reg;
    logic signed [lbbr_pkg::DIFF_W-1:0] udx2_reg;
    logic signed [lbbr_pkg::DIFF_W-1:0] udy2_reg;
    logic signed [lbbr_pkg::DIFF_W-1:0] bdx2_reg;
    logic signed [lbbr_pkg::DIFF_W-1:0] bdy2_reg;

    logic           v3_reg;
    lbbr_pkg::idx_t idx3_reg;
    lbbr_pkg::box_t box3_reg;
    logic signed [lbbr_pkg::AREA_W-1:0] au3_reg;
    logic signed [lbbr_pkg::AREA_W-1:0] ab3_reg;

    logic           v4_reg;
    lbbr_pkg::idx_t idx4_reg;
    lbbr_pkg::box_t box4_reg;
    logic signed [lbbr_pkg::GROWTH_W-1:0] growth4_reg;

    logic signed [lbbr_pkg::AREA_W-1:0]  area_r_reg;
    logic signed [lbbr_pkg::LIMIT_W-1:0] limit_reg;

    logic           hit_reg;
    logic           found_reg;
    lbbr_pkg::idx_t found_idx_reg;
    lbbr_pkg::box_t found_box_reg;
    logic           best_valid_reg;
    lbbr_pkg::idx_t best_idx_reg;
    lbbr_pkg::box_t best_box_reg;
    logic signed [lbbr_pkg::GROWTH_W-1:0] best_growth_reg;

    lbbr_pkg::box_t uni;
    logic           hit;
    logic signed [lbbr_pkg::LIMIT_W-1:0] growth_x4;
    logic           qual;

    always_comb
    begin
        uni.x0 = (ctl.rect.x0 < rd_data.x0) ? ctl.rect.x0 : rd_data.x0;
        uni.y0 = (ctl.rect.y0 < rd_data.y0) ? ctl.rect.y0 : rd_data.y0;
        uni.x1 = (ctl.rect.x1 > rd_data.x1) ? ctl.rect.x1 : rd_data.x1;
        uni.y1 = (ctl.rect.y1 > rd_data.y1) ? ctl.rect.y1 : rd_data.y1;
        hit    = (ctl.rect.x1 > rd_data.x0) && (ctl.rect.x0 < rd_data.x1) &&
                 (ctl.rect.y1 > rd_data.y0) && (ctl.rect.y0 < rd_data.y1);
    end

    assign growth_x4 = $signed({{(lbbr_pkg::LIMIT_W - lbbr_pkg::GROWTH_W - 2)
                                 {growth4_reg[lbbr_pkg::GROWTH_W-1]}},
                                growth4_reg, 2'b00});
    assign qual      = (growth_x4 <= limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        area_r_reg <= span(ctl.rect.x0, ctl.rect.x1) * span(ctl.rect.y0, ctl.rect.y1);
        limit_reg  <= $signed({1'b0, ctl.thr}) * area_r_reg;

        idx1_reg   <= ctl.rd_idx;

        idx2_reg   <= idx1_reg;
        box2_reg   <= uni;
        hit2_reg   <= hit;
        udx2_reg   <= span(uni.x0, uni.x1);
        udy2_reg   <= span(uni.y0, uni.y1);
        bdx2_reg   <= span(rd_data.x0, rd_data.x1);
        bdy2_reg   <= span(rd_data.y0, rd_data.y1);

        idx3_reg   <= idx2_reg;
        box3_reg   <= box2_reg;
        au3_reg    <= udx2_reg * udy2_reg;
        ab3_reg    <= bdx2_reg * bdy2_reg;

        idx4_reg    <= idx3_reg;
        box4_reg    <= box3_reg;
        growth4_reg <= $signed({au3_reg[lbbr_pkg::AREA_W-1], au3_reg}) -
                       $signed({ab3_reg[lbbr_pkg::AREA_W-1], ab3_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            found_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            hit_reg        <= 1'b0;
            found_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (v2_reg && hit2_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (v4_reg && !found_reg)
            begin
                if (qual)
                begin
                    found_reg <= 1'b1;
                end
                else if (!best_valid_reg || (growth4_reg < best_growth_reg))
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.start && v4_reg && !found_reg)
        begin
            if (qual)
            begin
                found_idx_reg <= idx4_reg;
                found_box_reg <= box4_reg;
            end
            else if (!best_valid_reg || (growth4_reg < best_growth_reg))
            begin
                best_idx_reg    <= idx4_reg;
                best_box_reg    <= box4_reg;
                best_growth_reg <= growth4_reg;
            end
        end
    end

    always_comb
    begin
        res.busy      = v1_reg || v2_reg || v3_reg || v4_reg;
        res.hit       = hit_reg;
        res.found     = found_reg;
        res.found_idx = found_idx_reg;
        res.found_box = found_box_reg;
        res.best_idx  = best_idx_reg;
        res.best_box  = best_box_reg;
    end

endmodule

// ===== hw/rtl/loose_bounding_box_region_core.sv =====
// ----------------------------------------------------------------------------
// loose_bounding_box_region_core
// The input is stalled from acceptance until the result is written to the output
// registers, and a result waits while the previous result word is held by out_stall.
// The box store is read one box per cycle into the four-stage walk, and a new word is
// taken only after the core is through with the last one.
// Reset: box count cleared, threshold set to 2.0, box store left unwritten.
// ----------------------------------------------------------------------------
module loose_bounding_box_region_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [15:0] left,
    input  logic signed [15:0] top,
    input  logic signed [15:0] right,
    input  logic signed [15:0] bottom,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               overlap,
    output logic [3:0]         box_count,
    output logic [2:0]         box_touched,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);

    lbbr_pkg::state_t state_reg;
    lbbr_pkg::state_t state_next;

    lbbr_pkg::cnt_t   rd_cnt_reg;
    lbbr_pkg::cnt_t   used_reg;
    lbbr_pkg::cnt_t   used_next;
    logic [lbbr_pkg::THR_W-1:0] thr_reg;

    logic             kind_reg;
    lbbr_pkg::box_t   rect_reg;

    logic             out_valid_reg;
    logic             overlap_reg;
    logic [3:0]       box_count_reg;
    logic [2:0]       box_touched_reg;

    logic             accept;
    logic             rd_more;
    logic             rd_fire;
    logic             finish;
    logic             new_box;
    logic             wr_en;
    lbbr_pkg::idx_t   wr_idx;
    lbbr_pkg::box_t   wr_box;

    lbbr_pkg::box_t      rd_data;
    lbbr_pkg::walk_ctl_t ctl;
    lbbr_pkg::walk_res_t res;

    assign accept  = in_valid && !in_stall;
    assign rd_more = (rd_cnt_reg < used_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbbr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lbbr_pkg::ST_WALK;
                end
            end
            lbbr_pkg::ST_WALK:
            begin
                if (!rd_more && !res.busy)
                begin
                    state_next = lbbr_pkg::ST_DONE;
                end
            end
            lbbr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = lbbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_fire  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            lbbr_pkg::ST_IDLE: in_stall = 1'b0;
            lbbr_pkg::ST_WALK: rd_fire  = rd_more;
            lbbr_pkg::ST_DONE: finish   = !out_valid_reg || !out_stall;
            default:           in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        new_box   = (kind_reg == lbbr_pkg::KIND_ADD) && !res.found &&
                    (used_reg < lbbr_pkg::CNT_W'(lbbr_pkg::MAX_BOXES));
        used_next = new_box ? used_reg + lbbr_pkg::CNT_W'(1) : used_reg;
        wr_en     = finish && (kind_reg == lbbr_pkg::KIND_ADD);
        if (res.found)
        begin
            wr_idx = res.found_idx;
            wr_box = res.found_box;
        end
        else if (new_box)
        begin
            wr_idx = used_reg[lbbr_pkg::IDX_W-1:0];
            wr_box = rect_reg;
        end
        else
        begin
            wr_idx = res.best_idx;
            wr_box = res.best_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbbr_pkg::ST_IDLE;
            rd_cnt_reg    <= '0;
            used_reg      <= '0;
            thr_reg       <= lbbr_pkg::THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (accept)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_fire)
            begin
                rd_cnt_reg <= rd_cnt_reg + lbbr_pkg::CNT_W'(1);
            end
            if (finish)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            rect_reg.x0 <= left;
            rect_reg.y0 <= top;
            rect_reg.x1 <= right;
            rect_reg.y1 <= bottom;
        end
        if (finish)
        begin
            overlap_reg     <= (kind_reg == lbbr_pkg::KIND_QUERY) && res.hit;
            box_count_reg   <= 4'(used_next);
            box_touched_reg <= (kind_reg == lbbr_pkg::KIND_ADD) ? 3'(wr_idx) : 3'd0;
        end
    end

    always_comb
    begin
        ctl.start   = accept;
        ctl.rd_fire = rd_fire;
        ctl.rd_idx  = rd_cnt_reg[lbbr_pkg::IDX_W-1:0];
        ctl.rect    = rect_reg;
        ctl.thr     = thr_reg;
    end

    lbbr_box_mem u_mem (
        .clk     (clk),
        .rd_en   (rd_fire),
        .rd_addr (rd_cnt_reg[lbbr_pkg::IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_box)
    );

    lbbr_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rd_data),
        .res     (res)
    );

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign overlap     = overlap_reg;
    assign box_count   = box_count_reg;
    assign box_touched = box_touched_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= lbbr_pkg::CNT_W'(lbbr_pkg::MAX_BOXES))
        else $error("box count above capacity");

    a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |->
            ($past(state_reg) == lbbr_pkg::ST_DONE) &&
            ($past(kind_reg) == lbbr_pkg::KIND_ADD))
        else $error("box count changed outside an add write back");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !res.found && !res.hit)
        else $error("walk tracker not cleared on new word");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overlap_reg |-> (box_touched_reg == 3'd0))
        else $error("query result carries a touched box");
`endif

endmodule
